FILE: src/msc_pkg.sv
// Shared types and constants for the Manning surface conductivity pipeline.
// No dependencies.
package msc_pkg;

	localparam int LOG_W   = 40;	// signed Q8.32 log2 value
	localparam int LOG_LAT = 34;
	localparam int EXP_LAT = 33;
	localparam int SQ_STAGES = 16;

	localparam logic [33:0] ONE_Q28 = 34'd268435456;
	localparam logic [31:0] EXPONENT_RST = 32'd178956971;
	localparam logic [47:0] EPSILON_RST  = 48'd10995;

	localparam logic CFG_MANNING_EXPONENT = 1'b0;
	localparam logic CFG_SLOPE_EPSILON    = 1'b1;

	typedef enum logic [1:0] {
		REQ_COND    = 2'd0,
		REQ_DERIV   = 2'd1,
		REQ_SUBGRID = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		OVR_NONE = 2'd0,
		OVR_ZERO = 2'd1,
		OVR_SAT  = 2'd2
	} ovr_t;

	typedef struct packed {
		req_t               req;
		logic [31:0]        depth;
		logic [31:0]        coef;
		logic [31:0]        pdd;
		logic [30:0]        frac;
		logic signed [31:0] beta;
	} fld_t;

	typedef struct packed {
		req_t               req;
		ovr_t               ovr;
		logic signed [33:0] e1;
		logic signed [33:0] e2;
	} ctl_t;

	function automatic logic [31:0] isqrt64(input logic [63:0] x);
		logic [31:0] r;
		logic [31:0] cand;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = r | (32'd1 << b);
			if ({32'd0, cand} * {32'd0, cand} <= x)
				r = cand;
		end
		return r;
	endfunction

	// k-th root-of-two factor 2^(2^-k), Q1.31
	function automatic logic [31:0] exp2_coef(input int k);
		logic [63:0] c;
		c = 64'd1 << 32;
		for (int j = 1; j <= k; j++)
			c = {32'd0, isqrt64(c << 31)};
		return c[31:0];
	endfunction

endpackage

FILE: src/manning_surface_conductivity_unit.sv
// Manning surface conductivity unit: one request per cycle unless stalled, one result each.
// Stages: input, slope sqrt, divisor multiply, log2, scale, sum, exp2, output
// buffer. Throughput one request per cycle unless the pipeline stalls, which
// happens when the 2-entry output buffer is full and m_tready is low.
// arst_n clears valid state and restores register defaults (2/3, 1e-8).
// Depends on msc_pkg, msc_log2, msc_exp2.
module manning_surface_conductivity_unit import msc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [0:0]   wr_index,
	input  logic [47:0]  wr_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// depth, slope, manning_coef, ponded_depth_diff, cond_fraction, beta, zero pad
	input  logic [207:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// value
	output logic [63:0]  m_tdata,
	// saturated
	output logic [0:0]   m_tuser
);

	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] root;
	} sq_t;

	function automatic sq_t sqrt_bit(input sq_t a, input int b);
		logic [65:0] test;
		sq_t r;
		test = (({34'd0, a.root} << 1) + (66'd1 << b)) << b;
		r = a;
		if ({2'b00, a.rem} >= test) begin
			r.rem  = a.rem - test[63:0];
			r.root = a.root | (32'd1 << b);
		end
		return r;
	endfunction

	logic [31:0] exponent_q;
	logic [47:0] epsilon_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= EXPONENT_RST;
			epsilon_q  <= EPSILON_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_MANNING_EXPONENT: exponent_q <= wr_data[31:0];
				CFG_SLOPE_EPSILON:    epsilon_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// input stage and slope square root
	fld_t        fld_sq [0:SQ_STAGES];
	sq_t         sq_sq  [0:SQ_STAGES];
	logic        v_sq   [0:SQ_STAGES];
	logic [47:0] seff_c;
	fld_t        fld_in;

	assign s_tready = en;
	assign seff_c = (s_tdata[79:32] > epsilon_q) ? s_tdata[79:32] : epsilon_q;
	assign fld_in = '{req: req_t'(s_tuser), depth: s_tdata[31:0], coef: s_tdata[111:80],
		pdd: s_tdata[143:112], frac: s_tdata[174:144], beta: s_tdata[206:175]};

	always_ff @(posedge clk) begin
		if (en) begin
			fld_sq[0] <= fld_in;
			sq_sq[0]  <= '{rem: {seff_c, 16'd0}, root: 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sq[0] <= 1'b0;
		else if (en) v_sq[0] <= s_tvalid;
	end

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (en) begin
				sq_sq[j+1]  <= sqrt_bit(sqrt_bit(sq_sq[j], 31 - 2*j), 30 - 2*j);
				fld_sq[j+1] <= fld_sq[j];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sq[j+1] <= 1'b0;
			else if (en) v_sq[j+1] <= v_sq[j];
		end
	end

	// divisor multiply and operand select
	fld_t               f_c;
	logic [31:0]        root_c;
	logic signed [33:0] e1_c;
	logic signed [33:0] e2_c;
	logic [33:0]        mp1_c;
	ovr_t               ovr_c;
	logic [63:0]        div_ml;
	logic [63:0]        la_x_ml;
	logic [63:0]        lb_x_ml;
	logic signed [7:0]  lb_off_ml;
	ctl_t               ctl_ml;
	logic               v_ml;

	assign f_c    = fld_sq[SQ_STAGES];
	assign root_c = sq_sq[SQ_STAGES].root;
	assign mp1_c  = {2'b00, exponent_q} + ONE_Q28;
	assign e1_c   = (f_c.req == REQ_DERIV) ? $signed({2'b00, exponent_q}) : $signed(mp1_c);
	assign e2_c   = $signed({{2{f_c.beta[31]}}, f_c.beta}) + $signed(ONE_Q28);

	always_comb begin
		if (f_c.req == REQ_NONE)
			ovr_c = OVR_ZERO;
		else if ((f_c.req == REQ_SUBGRID) ? (f_c.pdd == '0) : (f_c.depth == '0))
			ovr_c = OVR_ZERO;
		else if (f_c.coef == '0 || root_c == '0)
			ovr_c = OVR_SAT;
		else if (f_c.req == REQ_SUBGRID && f_c.frac == '0)
			ovr_c = (e2_c > 34'sd0) ? OVR_ZERO : OVR_SAT;
		else
			ovr_c = OVR_NONE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_ml  <= {32'd0, f_c.coef} * {32'd0, root_c};
			la_x_ml <= {32'd0, (f_c.req == REQ_SUBGRID) ? f_c.pdd : f_c.depth};
			case (f_c.req)
				REQ_DERIV: begin
					lb_x_ml   <= {30'd0, mp1_c};
					lb_off_ml <= -8'sd28;
				end
				REQ_SUBGRID: begin
					lb_x_ml   <= {33'd0, f_c.frac};
					lb_off_ml <= -8'sd30;
				end
				default: begin
					lb_x_ml   <= 64'd1;
					lb_off_ml <= 8'sd0;
				end
			endcase
			ctl_ml <= '{req: f_c.req, ovr: ovr_c, e1: e1_c, e2: e2_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_ml <= 1'b0;
		else if (en) v_ml <= v_sq[SQ_STAGES];
	end

	// log2 of the three operands
	logic signed [LOG_W-1:0] la_lg;
	logic signed [LOG_W-1:0] lb_lg;
	logic signed [LOG_W-1:0] ld_lg;
	ctl_t                    ctl_lg [1:LOG_LAT];
	logic                    v_lg   [1:LOG_LAT];

	msc_log2 u_log_a (.clk(clk), .en(en), .x(la_x_ml), .off(-8'sd16), .lg(la_lg));
	msc_log2 u_log_b (.clk(clk), .en(en), .x(lb_x_ml), .off(lb_off_ml), .lg(lb_lg));
	msc_log2 u_log_d (.clk(clk), .en(en), .x(div_ml), .off(-8'sd52), .lg(ld_lg));

	for (genvar i = 1; i <= LOG_LAT; i++) begin : g_lgdly
		always_ff @(posedge clk) begin
			if (en) ctl_lg[i] <= (i == 1) ? ctl_ml : ctl_lg[(i == 1) ? 1 : i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_lg[i] <= 1'b0;
			else if (en) v_lg[i] <= (i == 1) ? v_ml : v_lg[(i == 1) ? 1 : i-1];
		end
	end

	// exponent scaling
	logic signed [31:0]      la_sh_c;
	logic signed [31:0]      lb_sh_c;
	logic signed [65:0]      p1_c;
	logic signed [65:0]      p2_c;
	logic signed [45:0]      t1_sc;
	logic signed [45:0]      t2_sc;
	logic signed [LOG_W-1:0] lb_sc;
	logic signed [LOG_W-1:0] ld_sc;
	ctl_t                    ctl_sc;
	logic                    v_sc;

	assign la_sh_c = la_lg[LOG_W-1:8];
	assign lb_sh_c = lb_lg[LOG_W-1:8];
	assign p1_c = la_sh_c * ctl_lg[LOG_LAT].e1;
	assign p2_c = lb_sh_c * ctl_lg[LOG_LAT].e2;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_sc  <= p1_c[65:20];
			t2_sc  <= p2_c[65:20];
			lb_sc  <= lb_lg;
			ld_sc  <= ld_lg;
			ctl_sc <= ctl_lg[LOG_LAT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sc <= 1'b0;
		else if (en) v_sc <= v_lg[LOG_LAT];
	end

	// log sum and range check
	logic signed [47:0] add_c;
	logic signed [47:0] r_c;
	ovr_t               ovr_f_c;
	ovr_t               ovr_sm;
	logic [5:0]         ip_sm;
	logic [31:0]        fr_sm;
	logic               v_sm;

	always_comb begin
		case (ctl_sc.req)
			REQ_DERIV:   add_c = {{8{lb_sc[LOG_W-1]}}, lb_sc};
			REQ_SUBGRID: add_c = {{2{t2_sc[45]}}, t2_sc};
			default:     add_c = '0;
		endcase
		r_c = {{2{t1_sc[45]}}, t1_sc} - {{8{ld_sc[LOG_W-1]}}, ld_sc} + add_c
			+ 48'sh20_0000_0000;
		if (ctl_sc.ovr != OVR_NONE)
			ovr_f_c = ctl_sc.ovr;
		else if (r_c >= 48'sh40_0000_0000)
			ovr_f_c = OVR_SAT;
		else if (r_c < 48'sd0)
			ovr_f_c = OVR_ZERO;
		else
			ovr_f_c = OVR_NONE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovr_sm <= ovr_f_c;
			ip_sm  <= r_c[37:32];
			fr_sm  <= r_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sm <= 1'b0;
		else if (en) v_sm <= v_sc;
	end

	// exp2 and output buffer
	logic [63:0] val_ex;
	logic        sat_ex;
	logic        v_ex [1:EXP_LAT];

	msc_exp2 u_exp (.clk(clk), .en(en), .ovr(ovr_sm), .ip(ip_sm), .fr(fr_sm),
		.value(val_ex), .saturated(sat_ex));

	for (genvar i = 1; i <= EXP_LAT; i++) begin : g_exdly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_ex[i] <= 1'b0;
			else if (en) v_ex[i] <= (i == 1) ? v_sm : v_ex[(i == 1) ? 1 : i-1];
		end
	end

	logic [63:0] buf_val_q [0:1];
	logic        buf_sat_q [0:1];
	logic [1:0]  cnt_q;
	logic [1:0]  fill_c;
	logic        push;
	logic        pop;

	assign en     = (cnt_q != 2'd2) || m_tready;
	assign push   = en && v_ex[EXP_LAT];
	assign pop    = m_tvalid && m_tready;
	assign fill_c = cnt_q - {1'b0, pop};

	always_ff @(posedge clk) begin
		if (push && !fill_c[0]) begin
			buf_val_q[0] <= val_ex;
			buf_sat_q[0] <= sat_ex;
		end else if (pop) begin
			buf_val_q[0] <= buf_val_q[1];
			buf_sat_q[0] <= buf_sat_q[1];
		end
		if (push && fill_c[0]) begin
			buf_val_q[1] <= val_ex;
			buf_sat_q[1] <= sat_ex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = buf_val_q[0];
	assign m_tuser  = buf_sat_q[0];

endmodule

FILE: src/msc_log2.sv
// Pipelined fixed-point log2: leading-one search, normalize, 32 squaring steps.
// Depends on msc_pkg.
module msc_log2 import msc_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic [63:0]             x,
	input  logic signed [7:0]       off,
	output logic signed [LOG_W-1:0] lg
);

	logic [63:0]       x_s1;
	logic [5:0]        msb_s1;
	logic signed [7:0] off_s1;
	logic [5:0]        msb_c;

	logic [31:0]       mant_s [0:32];
	logic [31:0]       frac_s [0:32];
	logic signed [7:0] int_s  [0:32];
	logic [63:0]       norm_c;

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < 64; i++)
			if (x[i]) msb_c = 6'(i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x;
			msb_s1 <= msb_c;
			off_s1 <= off;
		end
	end

	always_comb begin
		if (msb_s1 > 6'd31)
			norm_c = x_s1 >> (msb_s1 - 6'd31);
		else
			norm_c = x_s1 << (6'd31 - msb_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mant_s[0] <= norm_c[31:0];
			frac_s[0] <= '0;
			int_s[0]  <= $signed({2'b00, msb_s1}) + off_s1;
		end
	end

	for (genvar k = 0; k < 32; k++) begin : g_step
		logic [63:0] sq;
		logic [32:0] t;
		assign sq = {32'd0, mant_s[k]} * {32'd0, mant_s[k]};
		assign t  = sq[63:31];
		always_ff @(posedge clk) begin
			if (en) begin
				mant_s[k+1] <= t[32] ? t[32:1] : t[31:0];
				frac_s[k+1] <= frac_s[k] | ({31'd0, t[32]} << (31 - k));
				int_s[k+1]  <= int_s[k];
			end
		end
	end

	assign lg = {int_s[32], frac_s[32]};

endmodule

FILE: src/msc_exp2.sv
// Pipelined fixed-point exp2: 32 root-of-two multiply steps, final shift and clip.
// Depends on msc_pkg.
module msc_exp2 import msc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  ovr_t        ovr,
	input  logic [5:0]  ip,
	input  logic [31:0] fr,
	output logic [63:0] value,
	output logic        saturated
);

	logic [31:0] mant_s [0:32];
	logic [31:0] fr_s   [0:32];
	logic [5:0]  ip_s   [0:32];
	ovr_t        ovr_s  [0:32];
	logic [63:0] shf_c;

	assign mant_s[0] = 32'h8000_0000;
	assign fr_s[0]   = fr;
	assign ip_s[0]   = ip;
	assign ovr_s[0]  = ovr;

	for (genvar k = 1; k <= 32; k++) begin : g_step
		localparam logic [31:0] CK = exp2_coef(k);
		logic [63:0] prod;
		assign prod = {32'd0, mant_s[k-1]} * {32'd0, CK};
		always_ff @(posedge clk) begin
			if (en) begin
				mant_s[k] <= fr_s[k-1][32-k] ? prod[62:31] : mant_s[k-1];
				fr_s[k]   <= fr_s[k-1];
				ip_s[k]   <= ip_s[k-1];
				ovr_s[k]  <= ovr_s[k-1];
			end
		end
	end

	always_comb begin
		if (ip_s[32] >= 6'd31)
			shf_c = {32'd0, mant_s[32]} << (ip_s[32] - 6'd31);
		else
			shf_c = {32'd0, mant_s[32]} >> (6'd31 - ip_s[32]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (ovr_s[32])
				OVR_SAT: begin
					value     <= '1;
					saturated <= 1'b1;
				end
				OVR_ZERO: begin
					value     <= '0;
					saturated <= 1'b0;
				end
				default: begin
					value     <= shf_c;
					saturated <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: tb/sv/tb_manning_surface_conductivity_unit.sv
// Testbench for manning_surface_conductivity_unit: directed and random requests
// checked against a bit-exact fixed-point Manning conductivity predictor.
// Depends on msc_pkg and the unit under test.
`timescale 1ns / 100ps
module tb_manning_surface_conductivity_unit import msc_pkg::*;;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         wr_en = 1'b0;
	logic [0:0]   wr_index = '0;
	logic [47:0]  wr_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [207:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;

	manning_surface_conductivity_unit u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	localparam longint ONE32 = 64'sd4294967296;
	localparam longint ONE28 = 64'sd268435456;

	logic [31:0] exponent_q28;
	logic [47:0] epsilon_q40;
	logic [63:0] cond_value_q[$];
	logic        cond_sat_q[$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          hold_off = 1'b0;
	bit          done = 1'b0;

	function automatic longint fshift(longint v, int k);
		if (v >= 0) return v >>> k;
		return -((-v + ((64'sd1 << k) - 1)) >>> k);
	endfunction

	function automatic logic [63:0] sqrt_floor(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint log2_fix(logic [63:0] x, int fbits);
		int msb;
		logic [63:0] mant, frac;
		msb = 63;
		frac = 0;
		while (x[msb] == 1'b0) msb--;
		mant = (msb > 31) ? (x >> (msb - 31)) : (x << (31 - msb));
		for (int b = 31; b >= 0; b--) begin
			mant = (mant * mant) >> 31;
			if (mant >= 64'h1_0000_0000) begin
				mant = mant >> 1;
				frac[b] = 1'b1;
			end
		end
		return longint'(msb - fbits) * ONE32 + longint'(frac);
	endfunction

	function automatic longint scale_log(longint lg, longint e);
		return fshift(fshift(lg, 8) * e, 20);
	endfunction

	function automatic logic [63:0] exp2_fix(longint r, output bit sat);
		logic [63:0] c, mant, fr;
		int ip;
		sat = 1'b0;
		c = 64'd1 << 32;
		mant = 64'd1 << 31;
		if (r >= 64 * ONE32) begin
			sat = 1'b1;
			return '1;
		end
		if (r < 0) return 0;
		ip = int'(r >>> 32);
		fr = r & 64'hFFFF_FFFF;
		for (int k = 1; k <= 32; k++) begin
			c = sqrt_floor(c << 31);
			if (fr[32 - k]) mant = (mant * c) >> 31;
		end
		if (ip >= 31) return mant << (ip - 31);
		return mant >> (31 - ip);
	endfunction

	task automatic predict_cond(input req_t kind, input logic [31:0] depth,
			input logic [47:0] slope, input logic [31:0] coef, input logic [31:0] pdd,
			input logic [30:0] frac, input logic signed [31:0] beta);
		longint m, total, fe;
		logic [63:0] seff, divisor, val;
		bit sat;
		m = longint'(exponent_q28);
		val = 0;
		sat = 0;
		if (kind == REQ_NONE || (kind == REQ_SUBGRID ? pdd == 0 : depth == 0)) begin
			val = 0;
		end else begin
			seff = {16'd0, (slope > epsilon_q40) ? slope : epsilon_q40};
			divisor = {32'd0, coef} * sqrt_floor(seff << 16);
			fe = longint'(beta) + ONE28;
			if (divisor == 0) begin
				val = '1;
				sat = 1;
			end else if (kind == REQ_SUBGRID && frac == 0) begin
				if (fe <= 0) begin
					val = '1;
					sat = 1;
				end
			end else begin
				if (kind == REQ_COND)
					total = scale_log(log2_fix({32'd0, depth}, 16), m + ONE28);
				else if (kind == REQ_DERIV)
					total = log2_fix(m + ONE28, 28)
						+ scale_log(log2_fix({32'd0, depth}, 16), m);
				else
					total = scale_log(log2_fix({32'd0, pdd}, 16), m + ONE28)
						+ scale_log(log2_fix({33'd0, frac}, 30), fe);
				total = total - log2_fix(divisor, 52);
				val = exp2_fix(total + 32 * ONE32, sat);
			end
		end
		cond_value_q.push_back(val);
		cond_sat_q.push_back(sat);
	endtask

	task automatic send_request(input req_t kind, input logic [31:0] depth,
			input logic [47:0] slope, input logic [31:0] coef, input logic [31:0] pdd,
			input logic [30:0] frac, input logic signed [31:0] beta);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {1'b0, beta, frac, pdd, coef, slope, depth};
		predict_cond(kind, depth, slope, coef, pdd, frac, beta);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [47:0] data);
		s_tvalid <= 1'b0;
		while (cond_value_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == CFG_MANNING_EXPONENT) exponent_q28 = data[31:0];
		else epsilon_q40 = data;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// receiver and result check
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (cond_value_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 64'd0);
			end else begin
				if (m_tdata !== cond_value_q[0])
					report_mismatch("value", m_tdata, cond_value_q[0]);
				if (m_tuser[0] !== cond_sat_q[0])
					report_mismatch("saturated", {63'd0, m_tuser},
						{63'd0, cond_sat_q[0]});
				void'(cond_value_q.pop_front());
				void'(cond_sat_q.pop_front());
			end
		end
	end

	initial begin : receiver
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
			if (wait_n != 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000 && !done) begin
			$display("timeout");
			$display("** manning_surface_conductivity_unit: FAILED **");
			$finish;
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	task automatic test_extremes();
		send_request(REQ_COND, 32'd0, 48'd100, 32'd1 << 24, 0, 0, 0);
		send_request(REQ_DERIV, 32'd0, 48'd100, 32'd1 << 24, 0, 0, 0);
		send_request(REQ_SUBGRID, 32'd5, 48'd1, 32'd1, 32'd0, 31'd5, 0);
		send_request(REQ_COND, 32'd65536, 48'd1 << 40, 32'd0, 0, 0, 0);
		send_request(REQ_DERIV, '1, '1, '1, '1, '1, '1);
		send_request(REQ_COND, '1, 48'd1, 32'd1, '1, '1, 32'h7FFF_FFFF);
		send_request(REQ_COND, 32'd1, '1, '1, 0, 0, 0);
		send_request(REQ_SUBGRID, 32'd1, 48'd1 << 40, 32'd1 << 24, 32'd65536, 31'd0, 32'd0);
		send_request(REQ_SUBGRID, 32'd1, 48'd1 << 40, 32'd1 << 24, 32'd65536, 31'd0,
			-32'sd268435456);
		send_request(REQ_SUBGRID, 32'd1, 48'd1 << 40, 32'd1 << 24, 32'd65536, 31'd0,
			32'h8000_0000);
		send_request(REQ_SUBGRID, 0, 48'd1 << 38, 32'd3 << 22, 32'd1 << 18, 31'd1 << 30,
			32'h8000_0000);
		send_request(REQ_SUBGRID, 0, 48'd1 << 38, 32'd3 << 22, '1, 31'h7FFF_FFFF,
			32'h7FFF_FFFF);
		send_request(REQ_NONE, '1, '1, '1, '1, '1, '1);
		send_request(REQ_COND, 32'd1 << 16, 48'd0, 32'd1 << 24, 0, 0, 0);
	endtask

	task automatic test_random(input int count);
		req_t kind;
		logic [31:0] d, n;
		logic [47:0] s;
		for (int i = 0; i < count; i++) begin
			kind = req_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
			if ($urandom_range(0, 4) == 0) begin
				d = $urandom(); s = rand48(); n = $urandom();
			end else begin
				d = $urandom_range(1 << 10, 1 << 20);
				s = {$urandom_range(1 << 20, 1 << 30), 16'(0)} >> $urandom_range(0, 20);
				n = $urandom_range(1 << 20, 1 << 26);
			end
			if (i == count / 2) hold_off = 1'b1;
			send_request(kind, d, s, n, $urandom_range(0, 15) == 0 ? 0 : d ^ $urandom_range(0, 255),
				31'($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 1 << 30)),
				$urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 29) - (1 << 28));
		end
	endtask

	initial begin
		exponent_q28 = EXPONENT_RST;
		epsilon_q40 = EPSILON_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random(250);
		write_reg(CFG_MANNING_EXPONENT, 48'd0);
		write_reg(CFG_SLOPE_EPSILON, 48'd0);
		test_extremes();
		test_random(200);
		write_reg(CFG_MANNING_EXPONENT, 48'hFFFF_FFFF);
		write_reg(CFG_SLOPE_EPSILON, '1);
		test_random(150);
		write_reg(CFG_MANNING_EXPONENT, 48'd1 << 28);
		write_reg(CFG_SLOPE_EPSILON, 48'd1 << 30);
		test_random(200);
		write_reg(CFG_MANNING_EXPONENT, {16'd0, $urandom()});
		write_reg(CFG_SLOPE_EPSILON, rand48());
		test_random(200);
		s_tvalid <= 1'b0;
		while (cond_value_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		done = 1'b1;
		if (errors == 0) $display("** manning_surface_conductivity_unit: PASSED **");
		else $display("** manning_surface_conductivity_unit: FAILED **");
		$finish;
	end

endmodule
